@@ rtl/gasa_pkg.sv @@
package gasa_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 2048;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned DIM_W   = 12;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned ATLAS_W = 15;
  localparam int unsigned IDX_W   = 11;

  localparam logic [ATLAS_W-1:0] ATLAS_RESET = 15'd1024;
  localparam logic [COORD_W:0]   SHELF_PAD   = 17'd2;
  localparam logic [COORD_W-1:0] COORD_MAX   = 16'hFFFF;
  localparam logic [COORD_W-1:0] PEN_HOME    = 16'd1;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [DIM_W-1:0]   bearing_left;
    logic [DIM_W-1:0]   bearing_top;
    logic [DIM_W-1:0]   advance;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
  } entry_t;

  typedef struct packed {
    logic wrap;
    logic fit;
    logic place;
  } pen_cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               flush;
  } pen_stat_t;

  function automatic logic [COORD_W-1:0] sat16(input logic [COORD_W:0] v);
    sat16 = v[COORD_W] ? COORD_MAX : v[COORD_W-1:0];
  endfunction

endpackage

@@ rtl/gasa_entry_mem.sv @@
module gasa_entry_mem #(
  parameter int unsigned TABLE_ENTRIES = gasa_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IW-1:0]    waddr_i,
  input  gasa_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [IW-1:0]    raddr_i,
  output gasa_pkg::entry_t rdata_o
);

  gasa_pkg::entry_t mem [TABLE_ENTRIES];
  gasa_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/gasa_pen.sv @@
module gasa_pen (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [gasa_pkg::ATLAS_W-1:0]     atlas_size_i,
  input  logic [gasa_pkg::DIM_W-1:0]       width_i,
  input  logic [gasa_pkg::DIM_W-1:0]       height_i,
  input  gasa_pkg::pen_cmd_t               cmd_i,
  output gasa_pkg::pen_stat_t              stat_o
);

  logic [gasa_pkg::COORD_W-1:0] col_q, col_d;
  logic [gasa_pkg::COORD_W-1:0] row_q, row_d;
  logic [gasa_pkg::DIM_W-1:0]   shelf_q, shelf_d;
  logic [gasa_pkg::COORD_W:0]   col_adv, row_wrap, row_fit, atlas_ext;
  logic                         wrap_now, flush_now;

  always_comb begin
    atlas_ext = (gasa_pkg::COORD_W+1)'(atlas_size_i);
    col_adv   = (gasa_pkg::COORD_W+1)'(col_q) + (gasa_pkg::COORD_W+1)'(width_i)
              + gasa_pkg::SHELF_PAD;
    row_wrap  = (gasa_pkg::COORD_W+1)'(row_q) + (gasa_pkg::COORD_W+1)'(shelf_q)
              + gasa_pkg::SHELF_PAD;
    row_fit   = (gasa_pkg::COORD_W+1)'(row_q) + (gasa_pkg::COORD_W+1)'(height_i)
              + gasa_pkg::SHELF_PAD;
    wrap_now  = cmd_i.wrap && (col_adv >= atlas_ext);
    flush_now = cmd_i.fit && (row_fit >= atlas_ext);

    priority if (wrap_now) begin
      col_d   = gasa_pkg::PEN_HOME;
      row_d   = gasa_pkg::sat16(row_wrap);
      shelf_d = '0;
    end else if (flush_now) begin
      col_d   = gasa_pkg::PEN_HOME;
      row_d   = gasa_pkg::PEN_HOME;
      shelf_d = '0;
    end else if (cmd_i.place) begin
      col_d   = gasa_pkg::sat16(col_adv);
      row_d   = row_q;
      shelf_d = (height_i > shelf_q) ? height_i : shelf_q;
    end else begin
      col_d   = col_q;
      row_d   = row_q;
      shelf_d = shelf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= gasa_pkg::PEN_HOME;
      row_q   <= gasa_pkg::PEN_HOME;
      shelf_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      shelf_q <= shelf_d;
    end
  end

  assign stat_o.col   = col_q;
  assign stat_o.row   = row_q;
  assign stat_o.flush = flush_now;

endmodule

@@ rtl/glyph_atlas_shelf_allocator_core.sv @@
// Glyph cache with shelf packing for a square atlas.
// Request channel (s_axis): tuser selects lookup or insert, tdata carries the
// key and, for an insert, the bitmap size and metrics. Result channel
// (m_axis): one result per request with entry, atlas position and metrics.
// Config: cfg_we_i writes atlas_size; the user must do so only while the block
// is idle, as the block itself does not enforce it. Each request scans the used
// part of the entry table through one read port of the entry memory, one entry
// per cycle, comparing keys in one comparator. Entries fill from 0 upward, so a
// fill count marks the used entries. A hit or a lookup miss goes from the scan
// state to the output state; an insert passes the wrap, fit and write states
// on the way. The block returns to idle before the next request is taken; one
// request is in work at a time.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls, the following result holds until it drains.
// Reset empties the table, sets the pen to (1,1), the shelf height to 0 and
// atlas_size to 1024; no clearing pass is needed.
module glyph_atlas_shelf_allocator_core #(
  parameter int unsigned TABLE_ENTRIES = gasa_pkg::TABLE_ENTRIES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [14:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_code, glyph_width, glyph_height, bearing_left, bearing_top, advance_width
  input  logic [95:0]  s_axis_tdata,
  // req_type
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // entry_index, pos_x, pos_y, out_width, out_height, out_bearing_left,
  // out_bearing_top, out_advance
  output logic [103:0] m_axis_tdata,
  // hit, newly_placed, atlas_cleared
  output logic [2:0]   m_axis_tuser
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_WRAP, ST_FIT, ST_WRITE, ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic [gasa_pkg::ATLAS_W-1:0] atlas_q, atlas_d;
  logic [CW-1:0] count_q, count_d, scan_q, scan_d;
  logic          rdv_q, rdv_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  logic          m_valid_q, m_valid_d;
  logic [103:0]  m_data_q, m_data_d;
  logic [2:0]    m_user_q, m_user_d;

  logic          req_q;
  gasa_pkg::entry_t req_ent_q, res_ent_q, res_ent_d;
  logic [gasa_pkg::IDX_W-1:0] res_idx_q, res_idx_d;
  logic [2:0]    res_flags_q, res_flags_d;

  logic          accept, key_match, rd_en, full, wr_en;
  logic [IW-1:0] wr_idx;
  gasa_pkg::entry_t rd_ent, wr_ent;
  gasa_pkg::pen_cmd_t  pen_cmd;
  gasa_pkg::pen_stat_t pen_stat;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign rd_en     = (state_q == ST_SCAN) && (scan_q < count_q);
  assign key_match = (state_q == ST_SCAN) && rdv_q && (rd_ent.key == req_ent_q.key);
  assign full      = (count_q == FULL_COUNT);
  assign wr_idx    = full ? '0 : count_q[IW-1:0];
  assign wr_en     = (state_q == ST_WRITE);

  always_comb begin
    wr_ent       = req_ent_q;
    wr_ent.pos_x = pen_stat.col;
    wr_ent.pos_y = pen_stat.row;
  end

  assign pen_cmd.wrap  = (state_q == ST_WRAP);
  assign pen_cmd.fit   = (state_q == ST_FIT);
  assign pen_cmd.place = wr_en;

  gasa_entry_mem #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_idx),
    .wdata_i(wr_ent),
    .re_i   (rd_en),
    .raddr_i(scan_q[IW-1:0]),
    .rdata_o(rd_ent)
  );

  gasa_pen u_pen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .atlas_size_i(atlas_q),
    .width_i     (req_ent_q.width),
    .height_i    (req_ent_q.height),
    .cmd_i       (pen_cmd),
    .stat_o      (pen_stat)
  );

  always_comb begin
    state_d     = state_q;
    atlas_d     = cfg_we_i ? cfg_wdata_i : atlas_q;
    count_d     = count_q;
    scan_d      = scan_q;
    rdv_d       = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;
    m_user_d    = m_user_q;
    res_ent_d   = res_ent_q;
    res_idx_d   = res_idx_q;
    res_flags_d = res_flags_q;
    unique case (state_q)
      ST_IDLE: begin
        scan_d = '0;
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          scan_d    = scan_q + 1'b1;
          rdv_d     = 1'b1;
          cmp_idx_d = scan_q[IW-1:0];
        end
        if (key_match) begin
          res_ent_d   = rd_ent;
          res_idx_d   = gasa_pkg::IDX_W'(cmp_idx_q);
          res_flags_d = 3'b001;
          state_d     = ST_OUT;
        end else if (!rd_en) begin
          if (req_q == gasa_pkg::REQ_INSERT) begin
            state_d = ST_WRAP;
          end else begin
            res_ent_d   = '0;
            res_idx_d   = '0;
            res_flags_d = '0;
            state_d     = ST_OUT;
          end
        end
      end
      ST_WRAP: begin
        state_d = ST_FIT;
      end
      ST_FIT: begin
        res_flags_d = {pen_stat.flush, 2'b11};
        if (pen_stat.flush) begin
          count_d = '0;
        end
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        res_ent_d = wr_ent;
        res_idx_d = gasa_pkg::IDX_W'(wr_idx);
        if (!full) begin
          count_d = count_q + 1'b1;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, res_ent_q.advance, res_ent_q.bearing_top,
                       res_ent_q.bearing_left, res_ent_q.height, res_ent_q.width,
                       res_ent_q.pos_y, res_ent_q.pos_x, res_idx_q};
          m_user_d  = res_flags_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      atlas_q   <= gasa_pkg::ATLAS_RESET;
      count_q   <= '0;
      scan_q    <= '0;
      rdv_q     <= 1'b0;
      cmp_idx_q <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
    end else begin
      state_q   <= state_d;
      atlas_q   <= atlas_d;
      count_q   <= count_d;
      scan_q    <= scan_d;
      rdv_q     <= rdv_d;
      cmp_idx_q <= cmp_idx_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_user_q  <= m_user_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q                  <= s_axis_tuser[0];
      req_ent_q.key          <= s_axis_tdata[31:0];
      req_ent_q.width        <= s_axis_tdata[43:32];
      req_ent_q.height       <= s_axis_tdata[55:44];
      req_ent_q.bearing_left <= s_axis_tdata[67:56];
      req_ent_q.bearing_top  <= s_axis_tdata[79:68];
      req_ent_q.advance      <= s_axis_tdata[91:80];
      req_ent_q.pos_x        <= '0;
      req_ent_q.pos_y        <= '0;
    end
    res_ent_q   <= res_ent_d;
    res_idx_q   <= res_idx_d;
    res_flags_q <= res_flags_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
